// ===== rtl/qrs_pkg.sv =====
// Shared constants and arithmetic helpers for the QRS preprocessing filter chain.
`default_nettype none

package qrs_pkg;

    localparam int DataWidth    = 32;
    localparam int SampleWidth  = 16;
    localparam int WindowLength = 30;

    localparam int RawTaps = 12;
    localparam int LpTaps  = 32;
    localparam int HpTaps  = 4;

    localparam int CountWidth = 4;
    localparam int StageCount = 8;

    localparam int DivShift      = 37;
    localparam int DivMagicWidth = DivShift + 1;
    localparam int ProdWidth     = DataWidth + DivMagicWidth;
    localparam logic [DivMagicWidth-1:0] DivMagic = DivMagicWidth'(
        ((64'd1 << DivShift) + 64'(WindowLength) - 64'd1) / 64'(WindowLength));

    function automatic logic [DataWidth-1:0] sdiv_pow2(
        input logic [DataWidth-1:0] v,
        input int unsigned          sh
    );
        logic [DataWidth-1:0] bias;
        logic [DataWidth-1:0] sum;
        bias = v[DataWidth-1] ? ((DataWidth'(1) << sh) - DataWidth'(1)) : '0;
        sum  = v + bias;
        return DataWidth'($signed(sum) >>> sh);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/qrs_lowpass.sv =====
// Input register and recursive low-pass stage of the QRS filter chain.
`default_nettype none

module qrs_lowpass (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [qrs_pkg::SampleWidth-1:0] i_sample,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic [qrs_pkg::DataWidth-1:0]        o_lp
);

    localparam int Ext = qrs_pkg::DataWidth - qrs_pkg::SampleWidth;

    logic                            r_x_valid;
    logic [qrs_pkg::SampleWidth-1:0] r_x;
    logic                            r_lp_valid;
    logic [qrs_pkg::DataWidth-1:0]   r_lp;
    logic [qrs_pkg::DataWidth-1:0]   r_lp_prev;
    logic [qrs_pkg::SampleWidth-1:0] r_raw [qrs_pkg::RawTaps];

    logic                          lp_ready;
    logic                          lp_fire;
    logic [qrs_pkg::DataWidth-1:0] x_ext;
    logic [qrs_pkg::DataWidth-1:0] x6_ext;
    logic [qrs_pkg::DataWidth-1:0] x12_ext;
    logic [qrs_pkg::DataWidth-1:0] taps_sum;
    logic [qrs_pkg::DataWidth-1:0] n_lp;

    assign lp_ready = !r_lp_valid || i_ready;
    assign lp_fire  = r_x_valid && lp_ready;
    assign o_ready  = !r_x_valid || lp_ready;

    always_comb begin
        x_ext    = {{Ext{r_x[qrs_pkg::SampleWidth-1]}}, r_x};
        x6_ext   = {{Ext{r_raw[5][qrs_pkg::SampleWidth-1]}}, r_raw[5]};
        x12_ext  = {{Ext{r_raw[11][qrs_pkg::SampleWidth-1]}}, r_raw[11]};
        taps_sum = x_ext - (x6_ext << 1) + x12_ext;
        n_lp     = (r_lp << 1) - r_lp_prev + qrs_pkg::sdiv_pow2(taps_sum, 5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_valid  <= 1'b0;
            r_lp_valid <= 1'b0;
            r_lp       <= '0;
            r_lp_prev  <= '0;
            for (int k = 0; k < qrs_pkg::RawTaps; k++) begin
                r_raw[k] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_x_valid <= i_valid;
            end
            if (lp_ready) begin
                r_lp_valid <= r_x_valid;
            end
            if (lp_fire) begin
                r_lp      <= n_lp;
                r_lp_prev <= r_lp;
                r_raw[0]  <= r_x;
                for (int k = 1; k < qrs_pkg::RawTaps; k++) begin
                    r_raw[k] <= r_raw[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_x <= i_sample;
        end
    end

    assign o_valid = r_lp_valid;
    assign o_lp    = r_lp;

endmodule

`default_nettype wire

// ===== rtl/qrs_highpass.sv =====
// Recursive high-pass stage of the QRS filter chain.
`default_nettype none

module qrs_highpass (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [qrs_pkg::DataWidth-1:0] i_lp,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [qrs_pkg::DataWidth-1:0]      o_hp
);

    logic                          r_valid;
    logic [qrs_pkg::DataWidth-1:0] r_hp;
    logic [qrs_pkg::DataWidth-1:0] r_lph [qrs_pkg::LpTaps];

    logic                          fire;
    logic [qrs_pkg::DataWidth-1:0] n_hp;

    assign o_ready = !r_valid || i_ready;
    assign fire    = i_valid && o_ready;

    always_comb begin
        n_hp = r_hp - qrs_pkg::sdiv_pow2(i_lp, 5) + r_lph[15] - r_lph[16]
             + qrs_pkg::sdiv_pow2(r_lph[qrs_pkg::LpTaps-1], 5);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_hp    <= '0;
            for (int k = 0; k < qrs_pkg::LpTaps; k++) begin
                r_lph[k] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (fire) begin
                r_hp     <= n_hp;
                r_lph[0] <= i_lp;
                for (int k = 1; k < qrs_pkg::LpTaps; k++) begin
                    r_lph[k] <= r_lph[k-1];
                end
            end
        end
    end

    assign o_valid = r_valid;
    assign o_hp    = r_hp;

endmodule

`default_nettype wire

// ===== rtl/qrs_derivative.sv =====
// Five-point derivative stage followed by the squaring stage.
`default_nettype none

module qrs_derivative (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [qrs_pkg::DataWidth-1:0] i_hp,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [qrs_pkg::DataWidth-1:0]      o_sq
);

    logic                          r_d_valid;
    logic [qrs_pkg::DataWidth-1:0] r_d;
    logic                          r_sq_valid;
    logic [qrs_pkg::DataWidth-1:0] r_sq;
    logic [qrs_pkg::DataWidth-1:0] r_hph [qrs_pkg::HpTaps];

    logic                          sq_ready;
    logic                          d_fire;
    logic                          sq_fire;
    logic [qrs_pkg::DataWidth-1:0] slope;
    logic [qrs_pkg::DataWidth-1:0] n_d;
    logic [qrs_pkg::DataWidth-1:0] n_sq;

    assign sq_ready = !r_sq_valid || i_ready;
    assign o_ready  = !r_d_valid || sq_ready;
    assign d_fire   = i_valid && o_ready;
    assign sq_fire  = r_d_valid && sq_ready;

    always_comb begin
        slope = (i_hp << 1) + r_hph[0] - r_hph[2] - (r_hph[3] << 1);
        n_d   = qrs_pkg::sdiv_pow2(slope, 3);
        n_sq  = r_d * r_d;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid  <= 1'b0;
            r_sq_valid <= 1'b0;
            for (int k = 0; k < qrs_pkg::HpTaps; k++) begin
                r_hph[k] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_d_valid <= i_valid;
            end
            if (sq_ready) begin
                r_sq_valid <= r_d_valid;
            end
            if (d_fire) begin
                r_hph[0] <= i_hp;
                for (int k = 1; k < qrs_pkg::HpTaps; k++) begin
                    r_hph[k] <= r_hph[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_fire) begin
            r_d <= n_d;
        end
        if (sq_fire) begin
            r_sq <= n_sq;
        end
    end

    assign o_valid = r_sq_valid;
    assign o_sq    = r_sq;

endmodule

`default_nettype wire

// ===== rtl/qrs_integrator.sv =====
// Moving-window sum of squares and its truncating division by the window length.
`default_nettype none

module qrs_integrator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [qrs_pkg::DataWidth-1:0] i_sq,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [qrs_pkg::DataWidth-1:0]      o_value
);

    logic                          r_sum_valid;
    logic [qrs_pkg::DataWidth-1:0] r_sum;
    logic [qrs_pkg::DataWidth-1:0] r_win [qrs_pkg::WindowLength];
    logic                          r_prod_valid;
    logic [qrs_pkg::ProdWidth-1:0] r_prod;
    logic                          r_prod_neg;
    logic                          r_out_valid;
    logic [qrs_pkg::DataWidth-1:0] r_out;

    logic                          prod_ready;
    logic                          out_ready;
    logic                          sum_fire;
    logic                          prod_fire;
    logic                          out_fire;
    logic [qrs_pkg::DataWidth-1:0] n_sum;
    logic [qrs_pkg::DataWidth-1:0] magnitude;
    logic [qrs_pkg::ProdWidth-1:0] n_prod;
    logic [qrs_pkg::DataWidth-1:0] quotient;
    logic [qrs_pkg::DataWidth-1:0] n_out;

    assign out_ready  = !r_out_valid || i_ready;
    assign prod_ready = !r_prod_valid || out_ready;
    assign o_ready    = !r_sum_valid || prod_ready;
    assign sum_fire   = i_valid && o_ready;
    assign prod_fire  = r_sum_valid && prod_ready;
    assign out_fire   = r_prod_valid && out_ready;

    always_comb begin
        n_sum     = r_sum - r_win[qrs_pkg::WindowLength-1] + i_sq;
        magnitude = r_sum[qrs_pkg::DataWidth-1] ? (~r_sum + qrs_pkg::DataWidth'(1)) : r_sum;
        n_prod    = qrs_pkg::ProdWidth'(magnitude) * qrs_pkg::ProdWidth'(qrs_pkg::DivMagic);
        quotient  = r_prod[qrs_pkg::DivShift +: qrs_pkg::DataWidth];
        n_out     = r_prod_neg ? (~quotient + qrs_pkg::DataWidth'(1)) : quotient;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_valid  <= 1'b0;
            r_prod_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_sum        <= '0;
            for (int k = 0; k < qrs_pkg::WindowLength; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (o_ready) begin
                r_sum_valid <= i_valid;
            end
            if (prod_ready) begin
                r_prod_valid <= r_sum_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_prod_valid;
            end
            if (sum_fire) begin
                r_sum    <= n_sum;
                r_win[0] <= i_sq;
                for (int k = 1; k < qrs_pkg::WindowLength; k++) begin
                    r_win[k] <= r_win[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (prod_fire) begin
            r_prod     <= n_prod;
            r_prod_neg <= r_sum[qrs_pkg::DataWidth-1];
        end
        if (out_fire) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_out;

endmodule

`default_nettype wire

// ===== rtl/qrs_preprocessing_filter_chain_top.sv =====
// Top level of the QRS preprocessing filter chain: low-pass, high-pass, derivative,
// squaring and moving-window integration.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_ready   i_ecg_sample (16 bits, signed)
//   output    out        o_out_valid / i_out_ready o_integrated_value (32 bits, signed)
//
// One transfer in and one transfer out per cycle unless the output stalls; a result
// passes registers r_x, r_lp, r_hp, r_d, r_sq, r_sum, r_prod and r_out in that order.
// The recursive low-pass and high-pass loops each close within a single stage.
// Reset clears every delay line, the filter feedback and the window sum.
// Each stage holds while the stage after it is full, so a stalled output only blocks
// the input once all eight stages are occupied.
`default_nettype none

module qrs_preprocessing_filter_chain_top (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire logic [qrs_pkg::SampleWidth-1:0] i_ecg_sample,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output logic [qrs_pkg::DataWidth-1:0]        o_integrated_value
);

    logic                          w_lp_valid;
    logic                          w_hp_ready;
    logic [qrs_pkg::DataWidth-1:0] w_lp;
    logic                          w_hp_valid;
    logic                          w_dv_ready;
    logic [qrs_pkg::DataWidth-1:0] w_hp;
    logic                          w_sq_valid;
    logic                          w_int_ready;
    logic [qrs_pkg::DataWidth-1:0] w_sq;

    qrs_lowpass u_lowpass (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_sample (i_ecg_sample),
        .o_valid  (w_lp_valid),
        .i_ready  (w_hp_ready),
        .o_lp     (w_lp)
    );

    qrs_highpass u_highpass (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_lp_valid),
        .o_ready (w_hp_ready),
        .i_lp    (w_lp),
        .o_valid (w_hp_valid),
        .i_ready (w_dv_ready),
        .o_hp    (w_hp)
    );

    qrs_derivative u_derivative (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_hp_valid),
        .o_ready (w_dv_ready),
        .i_hp    (w_hp),
        .o_valid (w_sq_valid),
        .i_ready (w_int_ready),
        .o_sq    (w_sq)
    );

    qrs_integrator u_integrator (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_sq_valid),
        .o_ready (w_int_ready),
        .i_sq    (w_sq),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_value (o_integrated_value)
    );

`ifndef SYNTHESIS
    logic [qrs_pkg::CountWidth-1:0] r_chk_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chk_count <= '0;
        end else begin
            r_chk_count <= r_chk_count
                         + qrs_pkg::CountWidth'(i_in_valid && o_in_ready)
                         - qrs_pkg::CountWidth'(o_out_valid && i_out_ready);
        end
    end

    a_in_stall_means_lp_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (w_lp_valid && !w_hp_ready))
        else $error("Input stalled while the low-pass stage could drain.");

    a_hp_stall_means_dv_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_hp_ready |-> (w_hp_valid && !w_dv_ready))
        else $error("High-pass stage stalled while the derivative stage could drain.");

    a_in_flight_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_count <= qrs_pkg::CountWidth'(qrs_pkg::StageCount))
        else $error("More items in flight than pipeline stages.");

    a_no_invented_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_chk_count != '0))
        else $error("Result offered with no input transfer outstanding.");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_qrs_preprocessing_filter_chain_top.sv =====
// Self-checking testbench for the QRS preprocessing filter chain, predicting all five stages.
module tb_qrs_preprocessing_filter_chain_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RawDepth  = 13;
    localparam int LpDepth   = 33;
    localparam int HpDepth   = 5;
    localparam int WinLength = qrs_pkg::WindowLength;
    localparam int PhaseGoal = 467;
    localparam int LongHold  = 300;
    localparam int SettleCycles = 24;

    typedef struct packed {
        logic [15:0] sample;
        logic        fixed;
        logic [31:0] value;
    } t_stim_row;

    localparam int DirectedCount = 24;
    localparam t_stim_row DirectedRows [DirectedCount] = '{
        '{16'h0000, 1'b1, 32'd0}, '{16'h0000, 1'b1, 32'd0},
        '{16'h0000, 1'b1, 32'd0}, '{16'h0000, 1'b1, 32'd0},
        '{16'h7FFF, 1'b0, 32'd0}, '{16'h8000, 1'b0, 32'd0},
        '{16'hFFFF, 1'b0, 32'd0}, '{16'h0001, 1'b0, 32'd0},
        '{16'h5555, 1'b0, 32'd0}, '{16'hAAAA, 1'b0, 32'd0},
        '{16'h7FFF, 1'b0, 32'd0}, '{16'h7FFF, 1'b0, 32'd0},
        '{16'h7FFF, 1'b0, 32'd0}, '{16'h7FFF, 1'b0, 32'd0},
        '{16'h7FFF, 1'b0, 32'd0}, '{16'h7FFF, 1'b0, 32'd0},
        '{16'h8000, 1'b0, 32'd0}, '{16'h8000, 1'b0, 32'd0},
        '{16'h8000, 1'b0, 32'd0}, '{16'h8000, 1'b0, 32'd0},
        '{16'h8000, 1'b0, 32'd0}, '{16'h8000, 1'b0, 32'd0},
        '{16'h0000, 1'b0, 32'd0}, '{16'h0000, 1'b0, 32'd0}
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    logic [qrs_pkg::SampleWidth-1:0] i_ecg_sample = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    logic [qrs_pkg::DataWidth-1:0]   o_integrated_value;

    int raw_hist [RawDepth];
    int lp_hist [LpDepth];
    int hp_hist [HpDepth];
    int square_hist [WinLength];
    int window_total;
    int raw_wr, lp_wr, hp_wr, win_wr;

    logic [31:0] pending_integrals [$];
    int send_idle_pct = 22;
    int recv_idle_pct = 67;
    int hold_requests, hold_served, hold_left;
    int samples_sent, results_checked, mismatches;

    qrs_preprocessing_filter_chain_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_ecg_sample       (i_ecg_sample),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_integrated_value (o_integrated_value)
    );

    always #5 i_clk = ~i_clk;

    // Ring offsets below are the write slot plus depth minus the look-back distance.
    function automatic int filter_chain_step(input logic [15:0] s);
        int x, t, lp, hp, d, sq;
        x = int'($signed(s));
        raw_hist[raw_wr] = x;
        t = x - 2 * raw_hist[(raw_wr + 7) % RawDepth] + raw_hist[(raw_wr + 1) % RawDepth];
        lp = 2 * lp_hist[(lp_wr + 32) % LpDepth] - lp_hist[(lp_wr + 31) % LpDepth] + t / 32;
        lp_hist[lp_wr] = lp;
        hp = hp_hist[(hp_wr + 4) % HpDepth] - lp / 32 + lp_hist[(lp_wr + 17) % LpDepth]
             - lp_hist[(lp_wr + 16) % LpDepth] + lp_hist[(lp_wr + 1) % LpDepth] / 32;
        hp_hist[hp_wr] = hp;
        t = 2 * hp + hp_hist[(hp_wr + 4) % HpDepth] - hp_hist[(hp_wr + 2) % HpDepth]
            - 2 * hp_hist[(hp_wr + 1) % HpDepth];
        d = t / 8;
        sq = d * d;
        window_total = window_total - square_hist[win_wr] + sq;
        square_hist[win_wr] = sq;
        raw_wr = (raw_wr + 1) % RawDepth;
        lp_wr = (lp_wr + 1) % LpDepth;
        hp_wr = (hp_wr + 1) % HpDepth;
        win_wr = (win_wr + 1) % WinLength;
        return window_total / WinLength;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic send_sample(input logic [15:0] s, input logic fixed,
                               input logic [31:0] fixed_value);
        int predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ecg_sample <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = filter_chain_step(s);
        pending_integrals.push_back(fixed ? fixed_value : 32'(predicted));
        samples_sent++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_integrals.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer with value %0d",
                                          $signed(o_integrated_value)));
            end else begin
                if (o_integrated_value !== pending_integrals[0]) begin
                    report_mismatch($sformatf("expected %0d, got %0d",
                                              $signed(pending_integrals[0]),
                                              $signed(o_integrated_value)));
                end
                void'(pending_integrals.pop_front());
                results_checked++;
            end
        end
        if (hold_served != hold_requests) begin
            hold_left = LongHold;
            hold_served++;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int row, phase, goal, kind, seg_len, half, level, k, wait_cycles;
        logic [15:0] s;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (row = 0; row < DirectedCount; row++) begin
            send_sample(DirectedRows[row].sample, DirectedRows[row].fixed,
                        DirectedRows[row].value);
        end

        for (phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 67;
                recv_idle_pct = 22;
            end
            if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_requests++;
            end
            goal = samples_sent + PhaseGoal;
            while (samples_sent < goal) begin
                kind = $urandom_range(3);
                seg_len = $urandom_range(40, 8);
                half = $urandom_range(20, 1);
                level = $urandom_range(65535);
                for (k = 0; k < seg_len; k++) begin
                    case (kind)
                        0: s = 16'($urandom);
                        1: s = ((k / half) % 2 != 0) ? 16'h8000 : 16'h7FFF;
                        2: s = ($urandom_range(15) == 0) ? 16'($urandom)
                                                         : 16'($urandom_range(256)) - 16'd128;
                        default: s = 16'(level);
                    endcase
                    send_sample(s, 1'b0, 32'd0);
                end
            end
            i_in_valid <= 1'b0;
            while (pending_integrals.size() != 0) @(posedge i_clk);
        end

        for (wait_cycles = 0; pending_integrals.size() != 0 && wait_cycles < 100000;
             wait_cycles++) begin
            @(posedge i_clk);
        end
        repeat (SettleCycles) @(posedge i_clk);
        if (pending_integrals.size() != 0) begin
            report_mismatch($sformatf("%0d expected transfers never arrived",
                                      pending_integrals.size()));
        end

        $display("%0d samples sent: start-up zeros, full-scale steps, %s",
                 samples_sent, "overload square waves, pulses, noise.");
        $display("%0d results checked under three stall mixes and one long output stall; %0d %s",
                 results_checked, mismatches, "mismatches.");
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
